FILE: rtl/core/qtbe_pkg.sv
// ----------------------------------------------------------------------------
// qtbe_pkg
// Shared types and constants of the quadtree bitmap encoder.
// ----------------------------------------------------------------------------
package qtbe_pkg;

    localparam int CFG_W = 9;

    // register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // code symbols
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_DIV  = 2'd2;

    // input modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // scan request / reply between sequencer and scan unit
    typedef struct packed {
        logic start;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic any_zero;
        logic any_one;
    } scan_rsp_t;

endpackage

FILE: rtl/core/quadtree_bitmap_encoder_core.sv
// ----------------------------------------------------------------------------
// quadtree_bitmap_encoder_core
// A load transfer (mode 0) writes the next raster pixel. A fetch transfer
// (mode 1) pops a region and walks it through the single pixel-store read
// port, one pixel per cycle; a divided region then pushes its quarters one
// at a time, and a fetch after the end is answered without a scan.
// Symbols come in preorder, 0 all zero, 1 all one, 2 divided; a region
// stack of STACK_DEPTH entries replaces recursion and quarters that do not
// fit are dropped.
// ----------------------------------------------------------------------------
module quadtree_bitmap_encoder_core import qtbe_pkg::*; #(
    parameter int MAX_DIM     = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] pixel
    input  logic             s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [1:0] symbol
    output logic             m_tlast,   // last_symbol
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int CW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POP  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_PUSH = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    typedef struct packed {
        logic [DW-1:0] rs, re, cs, ce;
    } region_t;

    logic [CFG_W-1:0] rows_raw_reg, cols_raw_reg;
    logic [DW-1:0]    rows, cols;
    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg;
    logic [SW-1:0]    top_reg, top_next;
    logic             done_reg, done_next;
    logic [1:0]       last_sym_reg, last_sym_next;
    logic [1:0]       sym_reg, sym_next;
    logic             tlast_reg, tlast_next;
    logic             mv_reg, mv_next;
    logic             bottom_whole_reg;
    region_t          stack [0:STACK_DEPTH-1];
    region_t          rd_reg, cur_reg, cur_next;
    logic [1:0]       qidx_reg, qidx_next;
    logic [DW-1:0]    rh, ch;
    region_t          quad;
    logic             push_en;
    logic             load_acc, fetch_acc;
    scan_req_t        sreq;
    scan_rsp_t        srsp;

    function automatic logic [DW-1:0] clamp(input logic [CFG_W-1:0] v);
        if (v == '0) return DW'(1);
        if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
        return DW'(v);
    endfunction

    assign rows = clamp(rows_raw_reg);
    assign cols = clamp(cols_raw_reg);

    assign s_tready  = (state_reg == ST_IDLE) && (!mv_reg || m_tready);
    assign load_acc  = s_tvalid && s_tready && (s_tuser == MODE_LOAD);
    assign fetch_acc = s_tvalid && s_tready && (s_tuser == MODE_FETCH);

    assign rh = DW'((DW+1)'(cur_reg.rs) + (DW+1)'(cur_reg.re) + 1'b1 >> 1);
    assign ch = DW'((DW+1)'(cur_reg.cs) + (DW+1)'(cur_reg.ce) + 1'b1 >> 1);

    // quarters in push order: bottom-right first so top-left pops first
    always_comb begin
        unique case (qidx_reg)
            2'd0:    quad = '{rs: rh, re: cur_reg.re, cs: ch, ce: cur_reg.ce};
            2'd1:    quad = '{rs: rh, re: cur_reg.re, cs: cur_reg.cs, ce: ch};
            2'd2:    quad = '{rs: cur_reg.rs, re: rh, cs: ch, ce: cur_reg.ce};
            default: quad = '{rs: cur_reg.rs, re: rh, cs: cur_reg.cs, ce: ch};
        endcase
    end

    assign push_en = (state_reg == ST_PUSH) && (quad.rs < quad.re) &&
                     (quad.cs < quad.ce) && (32'(top_reg) < STACK_DEPTH);

    always_ff @(posedge aclk) begin
        if (push_en) stack[IW'(top_reg)] <= quad;
        rd_reg <= stack[IW'(top_reg - 1'b1)];
    end

    always_comb begin
        state_next    = state_reg;
        top_next      = top_reg;
        done_next     = done_reg;
        last_sym_next = last_sym_reg;
        sym_next      = sym_reg;
        tlast_next    = tlast_reg;
        mv_next       = mv_reg;
        cur_next      = cur_reg;
        qidx_next     = qidx_reg;
        sreq.start    = 1'b0;
        if (mv_reg && m_tready) mv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (fetch_acc) begin
                    if (done_reg || top_reg == '0) begin
                        done_next  = 1'b1;
                        sym_next   = last_sym_reg;
                        tlast_next = 1'b1;
                        mv_next    = 1'b1;
                    end else begin
                        top_next   = top_reg - 1'b1;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                // bottom entry is the whole bitmap, built from the registers,
                // until a quarter is pushed over it
                cur_next   = (top_reg == '0 && bottom_whole_reg) ?
                             '{rs: '0, re: rows, cs: '0, ce: cols} : rd_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!srsp.done && sreq.start == 1'b0 && qidx_reg == 2'd3) begin
                    sreq.start = 1'b1;
                    qidx_next  = 2'd0;
                end else if (srsp.done) begin
                    qidx_next = 2'd3;
                    if (!srsp.any_one)       sym_next = SYM_ZERO;
                    else if (!srsp.any_zero) sym_next = SYM_ONE;
                    else                     sym_next = SYM_DIV;
                    if (srsp.any_one && srsp.any_zero) begin
                        qidx_next  = 2'd0;
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PUSH: begin
                if (push_en) top_next = top_reg + 1'b1;
                qidx_next = qidx_reg + 1'b1;
                if (qidx_reg == 2'd3) begin
                    qidx_next  = 2'd3;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                last_sym_next = sym_reg;
                if (top_reg == '0) done_next = 1'b1;
                tlast_next = (top_reg == '0);
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr_en) begin
            top_next  = SW'(1);
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_raw_reg     <= CFG_W'(1);
            cols_raw_reg     <= CFG_W'(1);
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            top_reg          <= SW'(1);
            done_reg         <= 1'b0;
            last_sym_reg     <= SYM_ZERO;
            mv_reg           <= 1'b0;
            qidx_reg         <= 2'd3;
            bottom_whole_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            done_reg     <= done_next;
            last_sym_reg <= last_sym_next;
            mv_reg       <= mv_next;
            qidx_reg     <= qidx_next;
            if (cfg_wr_en) begin
                bottom_whole_reg <= 1'b1;
            end else if (push_en && top_reg == '0) begin
                bottom_whole_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                cnt_reg <= '0;
                if (cfg_index == CFG_ROWS) rows_raw_reg <= cfg_wr_data;
                if (cfg_index == CFG_COLS) cols_raw_reg <= cfg_wr_data;
            end else if (load_acc && 32'(cnt_reg) < 32'(rows) * 32'(cols)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        sym_reg   <= sym_next;
        tlast_reg <= tlast_next;
        cur_reg   <= cur_next;
    end

    // the stack's bottom slot is read from the array only once a quarter fills it
    qtbe_scan #(.DW(DW), .AW(AW)) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_acc && 32'(cnt_reg) < 32'(rows) * 32'(cols)),
        .wr_addr (AW'(cnt_reg)),
        .wr_data (s_tdata[0]),
        .cols    (cols),
        .rs      (cur_reg.rs),
        .re      (cur_reg.re),
        .cs      (cur_reg.cs),
        .ce      (cur_reg.ce),
        .req     (sreq),
        .rsp     (srsp)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, sym_reg};
    assign m_tlast  = tlast_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE) else $error("ready while busy");
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(top_reg) <= STACK_DEPTH) else $error("stack overflow");
    a_out_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> mv_reg) else $error("result lost");

endmodule

FILE: rtl/core/qtbe_scan.sv
// ----------------------------------------------------------------------------
// qtbe_scan
// Pixel store plus region scanner: walks a region one pixel a cycle and
// reports whether it holds zeros and/or ones.
// ----------------------------------------------------------------------------
module qtbe_scan import qtbe_pkg::*; #(
    parameter int DW = 9,
    parameter int AW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [DW-1:0] cols,
    input  logic [DW-1:0] rs,
    input  logic [DW-1:0] re,
    input  logic [DW-1:0] cs,
    input  logic [DW-1:0] ce,
    input  scan_req_t     req,
    output scan_rsp_t     rsp
);

    logic mem [0:(1<<AW)-1];
    logic rd_data;

    logic [DW-1:0] r_reg, r_next, c_reg, c_next;
    logic [AW-1:0] base_reg, base_next;
    logic          busy_reg, busy_next;
    logic          rdv_reg, rdv_next;
    logic          last_reg, last_next;
    logic          z_reg, z_next, o_reg, o_next;
    logic          done_reg, done_next;
    logic [AW-1:0] rd_addr;

    assign rd_addr = base_reg + AW'(c_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb begin
        r_next    = r_reg;
        c_next    = c_reg;
        base_next = base_reg;
        busy_next = busy_reg;
        rdv_next  = 1'b0;
        last_next = 1'b0;
        z_next    = z_reg;
        o_next    = o_reg;
        done_next = 1'b0;
        if (req.start) begin
            r_next    = rs;
            c_next    = cs;
            // one multiply per region start
            base_next = AW'(rs) * AW'(cols);
            busy_next = 1'b1;
            z_next    = 1'b0;
            o_next    = 1'b0;
        end else if (busy_reg) begin
            rdv_next = 1'b1;
            if (c_reg + 1'b1 >= ce) begin
                c_next = cs;
                r_next = r_reg + 1'b1;
                base_next = base_reg + AW'(cols);
                if (r_reg + 1'b1 >= re) begin
                    busy_next = 1'b0;
                    last_next = 1'b1;
                end
            end else begin
                c_next = c_reg + 1'b1;
            end
        end
        if (rdv_reg) begin
            if (rd_data) o_next = 1'b1;
            else         z_next = 1'b1;
            if (last_reg) done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rdv_reg  <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            rdv_reg  <= rdv_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
        r_reg    <= r_next;
        c_reg    <= c_next;
        base_reg <= base_next;
        z_reg    <= z_next;
        o_reg    <= o_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.any_zero = z_reg;
    assign rsp.any_one  = o_reg;

    a_done_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(rdv_reg)) else $error("scan done without read");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("scan restarted while busy");
    a_result_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (z_reg || o_reg)) else $error("empty scan result");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for quadtree_bitmap_encoder_core. Bitmaps are loaded pixel by
// pixel and their quadtree code is fetched symbol by symbol. Every fetched
// symbol and its last flag is checked against a behavioural encoder that
// keeps its own pixel store, region stack and register copies.
// ----------------------------------------------------------------------------
module tb_top;
    import qtbe_pkg::*;

    localparam int MAX_DIM     = 256;
    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        int rs;
        int re;
        int cs;
        int ce;
    } quad_t;

    typedef struct {
        logic [1:0] symbol;
        logic       last;
    } code_sym_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;   // [0] pixel
    logic             s_tuser = 1'b0; // [0] mode
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;        // [1:0] symbol
    logic             m_tlast;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    // behavioural encoder state
    bit         px_mem [MAX_DIM*MAX_DIM];
    int         px_loaded;
    quad_t      quad_stack [STACK_DEPTH];
    int         quad_depth;
    bit         code_done;
    logic [1:0] prev_symbol;
    int         row_reg;
    int         col_reg;

    code_sym_t  pending_syms[$];
    int         err_count = 0;
    int         cycle_count = 0;
    int         items_sent = 0;
    bit         quiet = 1'b0;
    int         rx_hold = 0;

    quadtree_bitmap_encoder_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int eff_dim(int v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void restart_encoder();
        px_loaded = 0;
        code_done = 1'b0;
        quad_stack[0] = '{0, eff_dim(row_reg), 0, eff_dim(col_reg)};
        quad_depth = 1;
    endfunction

    function automatic void push_quad(int rs, int re, int cs, int ce);
        if (rs >= re || cs >= ce) return;
        if (quad_depth >= STACK_DEPTH) return;
        quad_stack[quad_depth] = '{rs, re, cs, ce};
        quad_depth++;
    endfunction

    // work out the symbol one fetch produces, and the stack update behind it
    function automatic code_sym_t encode_next();
        code_sym_t  res;
        quad_t      q;
        int         zeros;
        int         area;
        int         rh;
        int         ch;
        int         cols;
        cols = eff_dim(col_reg);
        if (code_done || quad_depth == 0) begin
            code_done = 1'b1;
            res.symbol = prev_symbol;
            res.last = 1'b1;
            return res;
        end
        quad_depth--;
        q = quad_stack[quad_depth];
        zeros = 0;
        for (int r = q.rs; r < q.re; r++)
            for (int c = q.cs; c < q.ce; c++)
                if (!px_mem[r*cols + c]) zeros++;
        area = (q.re - q.rs) * (q.ce - q.cs);
        if (zeros == area) begin
            res.symbol = SYM_ZERO;
        end else if (zeros == 0) begin
            res.symbol = SYM_ONE;
        end else begin
            res.symbol = SYM_DIV;
            rh = (q.rs + q.re + 1) / 2;
            ch = (q.cs + q.ce + 1) / 2;
            // reversed so the top-left quarter comes out first
            push_quad(rh, q.re, ch, q.ce);
            push_quad(rh, q.re, q.cs, ch);
            push_quad(q.rs, rh, ch, q.ce);
            push_quad(q.rs, rh, q.cs, ch);
        end
        prev_symbol = res.symbol;
        if (quad_depth == 0) code_done = 1'b1;
        res.last = code_done;
        return res;
    endfunction

    // result checker
    always @(posedge aclk) begin
        code_sym_t exp_sym;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_syms.size() == 0) begin
                $display("%0t: unexpected transfer, actual symbol %0d last %0b",
                         $time, m_tdata[1:0], m_tlast);
                err_count++;
            end else begin
                exp_sym = pending_syms.pop_front();
                if (m_tdata[1:0] !== exp_sym.symbol) begin
                    $display("%0t: symbol mismatch, expected %0d actual %0d",
                             $time, exp_sym.symbol, m_tdata[1:0]);
                    err_count++;
                end
                if (m_tlast !== exp_sym.last) begin
                    $display("%0t: last flag mismatch, expected %0b actual %0b",
                             $time, exp_sym.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            rx_hold <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic mode, logic pixel);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, pixel};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (mode == MODE_LOAD) begin
            if (px_loaded < eff_dim(row_reg) * eff_dim(col_reg)) begin
                px_mem[px_loaded] = pixel;
                px_loaded++;
            end
        end else begin
            pending_syms.push_back(encode_next());
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_syms.size() == 0);
        // a trailing load needs no result; let it settle too
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_ROWS) row_reg = val;
        else col_reg = val;
        restart_encoder();
    endtask

    task automatic set_size(int rows, int cols);
        write_reg(CFG_ROWS, rows[CFG_W-1:0]);
        write_reg(CFG_COLS, cols[CFG_W-1:0]);
    endtask

    // pattern 0 random, 1 all zero, 2 all one, 3 split along a row and column
    task automatic load_bitmap(int pattern, int count);
        int cols;
        int r0;
        int c0;
        logic px;
        cols = eff_dim(col_reg);
        r0 = $urandom_range(0, eff_dim(row_reg));
        c0 = $urandom_range(0, cols);
        for (int i = 0; i < count; i++) begin
            case (pattern)
                0: px = $urandom_range(0, 1);
                1: px = 1'b0;
                2: px = 1'b1;
                default: px = ((i / cols) >= r0) ^ ((i % cols) >= c0);
            endcase
            send_item(MODE_LOAD, px);
        end
    endtask

    task automatic fetch_code(int extra);
        while (!code_done) send_item(MODE_FETCH, 1'b0);
        repeat (extra) send_item(MODE_FETCH, 1'b0);
    endtask

    task automatic test_reset_size();
        load_bitmap(2, 1);
        fetch_code(2);
    endtask

    task automatic test_size_extremes();
        set_size(0, 511);           // clamps to one row of full width
        load_bitmap(3, MAX_DIM);
        fetch_code(1);
        set_size(256, 1);
        load_bitmap(3, MAX_DIM);
        fetch_code(1);
        set_size(2, 2);
        load_bitmap(1, 4);
        fetch_code(1);
    endtask

    task automatic test_overload();
        set_size(3, 3);
        load_bitmap(0, 9);
        load_bitmap(0, 3);          // ignored, the bitmap is full
        fetch_code(1);
    endtask

    task automatic test_early_fetch();
        // store still holds the previous 3x3 bitmap
        set_size(3, 3);
        load_bitmap(2, 4);
        fetch_code(0);
        write_reg(CFG_COLS, 9'd3);
        load_bitmap(1, 5);
        send_item(MODE_FETCH, 1'b0);
        load_bitmap(0, 4);          // still taken, count allows it
        fetch_code(1);
    endtask

    task automatic run_random(int target);
        int rows;
        int cols;
        int base;
        base = items_sent;
        while (items_sent - base < target) begin
            if (items_sent - base > target * 3 / 4) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0: begin rows = 1; cols = $urandom_range(100, 511); end
                1: begin rows = $urandom_range(0, 2); cols = $urandom_range(0, 3); end
                default: begin rows = $urandom_range(1, 8); cols = $urandom_range(1, 8); end
            endcase
            if (eff_dim(rows) * eff_dim(cols) > 300) rows = 1;
            set_size(rows, cols);
            load_bitmap($urandom_range(0, 3), eff_dim(rows) * eff_dim(cols));
            if ($urandom_range(0, 5) == 0) load_bitmap(0, $urandom_range(1, 3));
            fetch_code($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
    endtask

    initial begin
        row_reg = 1;
        col_reg = 1;
        prev_symbol = SYM_ZERO;
        restart_encoder();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_size();
        test_size_extremes();
        test_overload();
        test_early_fetch();
        run_random(RANDOM_ITEMS);
        wait_drained();
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: quadtree_bitmap_encoder_core.f
rtl/core/qtbe_pkg.sv
rtl/core/qtbe_scan.sv
rtl/core/quadtree_bitmap_encoder_core.sv
test/tb_top.sv
